// File: hw/rtl/wsds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsds_pkg: shared types and constants
// Request codes, result status codes, widths, the command and status structs and sat_add.
// ----------------------------------------------------------------------------
package wsds_pkg;
  localparam int QUERY_MAX_DEF  = 128;
  localparam int TRAJ_MAX_DEF   = 65536;
  localparam int WINDOW_MAX_DEF = 128;
  localparam int WLEN_RESET     = 100;
  localparam int COORD_W        = 24;
  localparam int COST_W         = 48;
  localparam int IDX_W          = 17;
  localparam int SQ_W           = 52;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_TRAJ  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic row_start;   // load trajectory point j, reset inner column k
    logic first_row;   // j == i
    logic cell_go;     // process one cell (column k)
    logic clear_best;
  } wsds_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_done;    // last cell of current row finished
    logic cell_done;   // a cell other than the last one finished
  } wsds_sts_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/wsds_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsds_isqrt: iterative integer square root
// Two radicand bits per cycle; start loads, done pulses with the root.
// ----------------------------------------------------------------------------
module wsds_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wsds_pkg::SQ_W-1:0]  radicand,
  output logic                            done,
  output logic [wsds_pkg::SQ_W/2-1:0]     root
);
  import wsds_pkg::*;
  localparam int STEPS = SQ_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [SQ_W-1:0]   rem_r, rem_nxt, x_r;
  logic [SQ_W/2-1:0] res_r, res_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic [SQ_W/2+1:0] trial, part;

  always_comb begin
    part    = {rem_r[SQ_W/2-1:0], x_r[SQ_W-1 -: 2]};
    trial   = {res_r, 2'b01};
    rem_nxt = rem_r;
    res_nxt = {res_r[SQ_W/2-2:0], 1'b0};
    if (part >= trial) begin
      rem_nxt = {{(SQ_W/2-2){1'b0}}, part - trial};
      res_nxt = {res_r[SQ_W/2-2:0], 1'b1};
    end else begin
      rem_nxt = {{(SQ_W/2-2){1'b0}}, part};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        res_r  <= '0;
        x_r    <= radicand;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        x_r   <= {x_r[SQ_W-3:0], 2'b00};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign root = res_r;
endmodule
`default_nettype wire

// File: hw/rtl/wsds_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsds_datapath: point stores, distance unit, DTW row and best tracking
// Executes one DTW cell per command using the row memory and a sqrt unit.
// ----------------------------------------------------------------------------
module wsds_datapath #(
  parameter int QUERY_MAX = wsds_pkg::QUERY_MAX_DEF,
  parameter int TRAJ_MAX  = wsds_pkg::TRAJ_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_we,
  input  wire logic [$clog2(QUERY_MAX)-1:0]  q_waddr,
  input  wire logic                          t_we,
  input  wire logic [$clog2(TRAJ_MAX)-1:0]   t_waddr,
  input  wire logic [3*wsds_pkg::COORD_W-1:0] wdata,
  input  wire logic [$clog2(TRAJ_MAX)-1:0]   t_raddr,
  input  wire logic [$clog2(QUERY_MAX+1)-1:0] m_cnt,
  input  wire logic [wsds_pkg::IDX_W-1:0]    cur_i,
  input  wire logic [wsds_pkg::IDX_W-1:0]    cur_j,
  input  wire wsds_pkg::wsds_cmd_t           cmd,
  output wsds_pkg::wsds_sts_t                sts,
  output logic [wsds_pkg::COST_W-1:0]        best_cost,
  output logic [wsds_pkg::IDX_W-1:0]         best_start,
  output logic [wsds_pkg::IDX_W-1:0]         best_end
);
  import wsds_pkg::*;
  localparam int QAW = $clog2(QUERY_MAX);
  localparam int MW  = $clog2(QUERY_MAX + 1);
  localparam int PW  = 2 * COORD_W + 2;

  logic [3*COORD_W-1:0] qmem [QUERY_MAX];
  logic [3*COORD_W-1:0] tmem [TRAJ_MAX];
  logic [COST_W-1:0]    rowm [QUERY_MAX];

  logic [3*COORD_W-1:0] tpt_r, qpt_r;
  logic [COST_W-1:0]    up_r, left_r, diag_r, best_r;
  logic [MW-1:0]        k_r;
  logic                 have_r, first_r;
  // cell phases: read, difference, square, sum+sqrt start, wait and write
  typedef enum logic [2:0] {C_IDLE, C_RD, C_SQ, C_MUL, C_SUM, C_WAIT} cph_t;
  cph_t                 ph_r;
  logic signed [COORD_W:0] dx_r, dy_r, dz_r;
  logic signed [PW-1:0] dxx, dyy, dzz;
  logic [SQ_W-1:0]      sx_r, sy_r, sz_r, sum;
  logic                 sq_start, sq_done;
  logic [SQ_W/2-1:0]    root;
  logic [COST_W-1:0]    dcost, mn, cell_cost;

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= wdata;
    if (t_we) tmem[t_waddr] <= wdata;
  end

  assign sum      = sx_r + sy_r + sz_r;
  assign sq_start = (ph_r == C_SUM);
  wsds_isqrt u_isqrt (.clk, .rst_n, .start(sq_start), .radicand(sum),
                      .done(sq_done), .root);
  assign dcost = COST_W'(root);

  always_comb begin
    mn = up_r;
    if (k_r != '0) begin
      if (left_r < mn) mn = left_r;
      if (diag_r < mn) mn = diag_r;
    end
    if (first_r)
      cell_cost = (k_r == '0) ? dcost : sat_add(dcost, left_r);
    else
      cell_cost = sat_add(dcost, mn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= C_IDLE;
      have_r <= 1'b0;
      sts    <= '0;
      k_r    <= '0;
    end else begin
      sts <= '0;
      if (cmd.clear_best) have_r <= 1'b0;
      if (cmd.row_start) begin
        tpt_r   <= tmem[t_raddr];
        k_r     <= '0;
        first_r <= cmd.first_row;
      end
      unique case (ph_r)
        C_IDLE: if (cmd.cell_go) ph_r <= C_RD;
        C_RD: begin
          qpt_r <= qmem[k_r[QAW-1:0]];
          up_r  <= rowm[k_r[QAW-1:0]];
          ph_r  <= C_SQ;
        end
        C_SQ: begin
          dx_r <= $signed({tpt_r[3*COORD_W-1], tpt_r[3*COORD_W-1 -: COORD_W]})
                - $signed({qpt_r[3*COORD_W-1], qpt_r[3*COORD_W-1 -: COORD_W]});
          dy_r <= $signed({tpt_r[2*COORD_W-1], tpt_r[2*COORD_W-1 -: COORD_W]})
                - $signed({qpt_r[2*COORD_W-1], qpt_r[2*COORD_W-1 -: COORD_W]});
          dz_r <= $signed({tpt_r[COORD_W-1], tpt_r[COORD_W-1:0]})
                - $signed({qpt_r[COORD_W-1], qpt_r[COORD_W-1:0]});
          ph_r <= C_MUL;
        end
        C_MUL: ph_r <= C_SUM;
        C_SUM: ph_r <= C_WAIT;
        C_WAIT: if (sq_done) begin
          rowm[k_r[QAW-1:0]] <= cell_cost;
          left_r <= cell_cost;
          diag_r <= up_r;
          ph_r   <= C_IDLE;
          if (k_r == m_cnt - 1'b1) begin
            sts.row_done <= 1'b1;
            if (!have_r || cell_cost < best_r) begin
              have_r     <= 1'b1;
              best_r     <= cell_cost;
              best_start <= cur_i + 1'b1;
              best_end   <= cur_j + 1'b1;
            end
          end else begin
            sts.cell_done <= 1'b1;
            k_r <= k_r + 1'b1;
          end
        end
        default: ph_r <= C_IDLE;
      endcase
    end
  end

  // squares are taken one stage behind the differences
  assign dxx = PW'(dx_r) * PW'(dx_r);
  assign dyy = PW'(dy_r) * PW'(dy_r);
  assign dzz = PW'(dz_r) * PW'(dz_r);

  always_ff @(posedge clk) begin
    if (ph_r == C_MUL) begin
      sx_r <= SQ_W'(unsigned'(dxx));
      sy_r <= SQ_W'(unsigned'(dyy));
      sz_r <= SQ_W'(unsigned'(dzz));
    end
  end
  assign best_cost = best_r;
endmodule
`default_nettype wire

// File: hw/rtl/wsds_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsds_ctrl: search sequencer
// Walks start i, end j and query columns; issues cell commands to the datapath.
// ----------------------------------------------------------------------------
module wsds_ctrl #(
  parameter int TRAJ_MAX   = wsds_pkg::TRAJ_MAX_DEF,
  parameter int WINDOW_MAX = wsds_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [wsds_pkg::IDX_W-1:0] n_cnt,
  input  wire logic [7:0]                wlen,
  input  wire wsds_pkg::wsds_sts_t       sts,
  output wsds_pkg::wsds_cmd_t            cmd,
  output logic [$clog2(TRAJ_MAX)-1:0]    t_raddr,
  output logic [wsds_pkg::IDX_W-1:0]     cur_i,
  output logic [wsds_pkg::IDX_W-1:0]     cur_j,
  output logic                           done
);
  import wsds_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_ROW, S_CELL, S_WAIT} state_t;
  state_t           state_r;
  logic [IDX_W-1:0] i_r, j_r, end_r, w;

  always_comb begin
    w = IDX_W'(wlen);
    if (w == '0) w = IDX_W'(1);
    if (w > IDX_W'(WINDOW_MAX)) w = IDX_W'(WINDOW_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd     <= '0;
      done    <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      end_r   <= '0;
    end else begin
      cmd  <= '0;
      done <= 1'b0;
      unique case (state_r)
        S_IDLE: if (go) begin
          i_r   <= '0;
          j_r   <= '0;
          end_r <= (n_cnt > w) ? w : n_cnt;
          cmd.clear_best <= 1'b1;
          state_r <= S_ROW;
        end
        S_ROW: begin
          cmd.row_start <= 1'b1;
          cmd.first_row <= (j_r == i_r);
          state_r <= S_CELL;
        end
        S_CELL: begin
          cmd.cell_go <= 1'b1;
          state_r <= S_WAIT;
        end
        S_WAIT: if (sts.row_done) begin
          if (j_r + 1'b1 < end_r) begin
            j_r <= j_r + 1'b1;
            state_r <= S_ROW;
          end else if (i_r + 1'b1 < n_cnt) begin
            i_r   <= i_r + 1'b1;
            j_r   <= i_r + 1'b1;
            end_r <= (n_cnt - i_r - 1'b1 > w) ? i_r + 1'b1 + w : n_cnt;
            state_r <= S_ROW;
          end else begin
            done <= 1'b1;
            state_r <= S_IDLE;
          end
        end else if (sts.cell_done) begin
          // column finished but not the row: next cell
          state_r <= S_CELL;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
  // S_WAIT issues the next cell only once the datapath reports the current one
  assign t_raddr = j_r[$clog2(TRAJ_MAX)-1:0];
  assign cur_i   = i_r;
  assign cur_j   = j_r;
endmodule
`default_nettype wire

// File: hw/rtl/windowed_subsequence_dtw_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_subsequence_dtw_search: top level
// Loads query and trajectory points, runs a windowed subsequence DTW search.
// ----------------------------------------------------------------------------
// Point loads (req_type 0 and 1) are taken one per cycle while in_stall is low
// and give no result. A run item (req_type 2) searches every window of up to
// window_len points (clamped to 1..WINDOW_MAX) against the whole query and
// returns one result: lowest cost, 1-based start and end, and a status. Cells
// are computed one at a time, each local distance passing through the
// bit-serial square root (SQ_W/2 steps); the input stalls for the whole search.
// Empty or overflowed runs offer their result in the cycle after the run item
// is taken. Every run clears both stores. Write window_len only while idle.
module windowed_subsequence_dtw_search #(
  parameter int QUERY_MAX  = wsds_pkg::QUERY_MAX_DEF,
  parameter int TRAJ_MAX   = wsds_pkg::TRAJ_MAX_DEF,
  parameter int WINDOW_MAX = wsds_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [7:0]                    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic signed [wsds_pkg::COORD_W-1:0] in_px,
  input  wire logic signed [wsds_pkg::COORD_W-1:0] in_py,
  input  wire logic signed [wsds_pkg::COORD_W-1:0] in_pz,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsds_pkg::COST_W-1:0]        out_best_cost,
  output logic [wsds_pkg::IDX_W-1:0]         out_best_start,
  output logic [wsds_pkg::IDX_W-1:0]         out_best_end,
  output logic [1:0]                         out_status
);
  import wsds_pkg::*;
  localparam int QAW = $clog2(QUERY_MAX);
  localparam int TAW = $clog2(TRAJ_MAX);
  localparam int MW  = $clog2(QUERY_MAX + 1);

  logic [7:0]       wlen_r;
  logic [MW-1:0]    qcnt_r;
  logic [IDX_W-1:0] tcnt_r;
  logic             ovf_r, busy_r;
  logic             acc, q_we, t_we, go, sdone;
  wsds_cmd_t        cmd;
  wsds_sts_t        sts;
  logic [TAW-1:0]   t_raddr;
  logic [IDX_W-1:0] cur_i, cur_j, bstart, bend;
  logic [COST_W-1:0] bcost;

  // hold input while searching or while a result waits
  assign in_stall = busy_r || (out_valid && out_stall);
  assign acc  = in_valid && !in_stall;
  assign q_we = acc && in_req_type == REQ_QUERY && qcnt_r < MW'(QUERY_MAX);
  assign t_we = acc && in_req_type == REQ_TRAJ && tcnt_r < IDX_W'(TRAJ_MAX);
  assign go   = acc && in_req_type == REQ_RUN && !ovf_r && qcnt_r != '0 && tcnt_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r    <= 8'(WLEN_RESET);
      qcnt_r    <= '0;
      tcnt_r    <= '0;
      ovf_r     <= 1'b0;
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) wlen_r <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (q_we) qcnt_r <= qcnt_r + 1'b1;
      if (t_we) tcnt_r <= tcnt_r + 1'b1;
      if (acc && ((in_req_type == REQ_QUERY && !q_we) ||
                  (in_req_type == REQ_TRAJ && !t_we)))
        ovf_r <= 1'b1;
      if (acc && in_req_type == REQ_RUN) begin
        qcnt_r <= '0;
        tcnt_r <= '0;
        ovf_r  <= 1'b0;
        if (go) begin
          busy_r <= 1'b1;
        end else begin
          out_valid      <= 1'b1;
          out_best_cost  <= '0;
          out_best_start <= '0;
          out_best_end   <= '0;
          out_status     <= ovf_r ? ST_OVF : ST_EMPTY;
        end
      end
      if (sdone) begin
        busy_r         <= 1'b0;
        out_valid      <= 1'b1;
        out_best_cost  <= bcost;
        out_best_start <= bstart;
        out_best_end   <= bend;
        out_status     <= ST_OK;
      end
    end
  end

  // counts are cleared at go, so latch the search sizes
  logic [MW-1:0]    m_r;
  logic [IDX_W-1:0] n_r;
  always_ff @(posedge clk) if (go) begin
    m_r <= qcnt_r;
    n_r <= tcnt_r;
  end

  wsds_ctrl #(.TRAJ_MAX(TRAJ_MAX), .WINDOW_MAX(WINDOW_MAX)) u_ctrl (
    .clk, .rst_n, .go(go), .n_cnt(go ? tcnt_r : n_r), .wlen(wlen_r),
    .sts, .cmd, .t_raddr, .cur_i, .cur_j, .done(sdone));

  wsds_datapath #(.QUERY_MAX(QUERY_MAX), .TRAJ_MAX(TRAJ_MAX)) u_dp (
    .clk, .rst_n, .q_we, .q_waddr(qcnt_r[QAW-1:0]), .t_we,
    .t_waddr(tcnt_r[TAW-1:0]), .wdata({in_px, in_py, in_pz}), .t_raddr,
    .m_cnt(m_r), .cur_i, .cur_j, .cmd, .sts,
    .best_cost(bcost), .best_start(bstart), .best_end(bend));

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> in_stall) else $error("item accepted during search");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sdone |-> busy_r) else $error("search done while idle");
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    $past(sdone) |-> out_valid && out_status == ST_OK) else $error("bad result");
endmodule
`default_nettype wire

// File: tb/windowed_subsequence_dtw_search_tb.sv
// ----------------------------------------------------------------------------
// windowed_subsequence_dtw_search_tb: self-checking bench for the DTW search
// Loads query and trajectory points, issues run items under several window
// lengths, and checks every result against a behavioral DTW search.
// ----------------------------------------------------------------------------
module windowed_subsequence_dtw_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsds_pkg::*;

  localparam int QMAX = 128;
  localparam int TMAX = 65536;
  localparam int WMAX = 128;
  localparam longint CYCLE_LIMIT = 64'd20000000;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [IDX_W-1:0]  start;
    logic [IDX_W-1:0]  stop;
    logic [1:0]        status;
  } search_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_QUERY;
  logic signed [COORD_W-1:0] in_px = '0, in_py = '0, in_pz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COST_W-1:0] out_best_cost;
  logic [IDX_W-1:0] out_best_start, out_best_end;
  logic [1:0] out_status;

  windowed_subsequence_dtw_search i_dut (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_req_type, .in_px, .in_py, .in_pz,
    .out_valid, .out_stall, .out_best_cost, .out_best_start, .out_best_end,
    .out_status
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the block
  logic signed [COORD_W-1:0] qry_pts[QMAX][3];
  logic signed [COORD_W-1:0] trj_pts[TMAX][3];
  int unsigned qry_cnt, trj_cnt;
  bit overflowed;
  logic [7:0] win_len_reg;
  search_res_t expected_results[$];
  int errors;
  longint cycles;

  // Receiver control: long hold-off requested by the pressure test
  int hold_cycles;
  int stall_pct;

  function automatic logic [COST_W-1:0] add_sat(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [COST_W-1:0] point_dist(int unsigned t, int unsigned k);
    logic [63:0] acc;
    longint d;
    acc = 0;
    for (int c = 0; c < 3; c++) begin
      d = longint'(trj_pts[t][c]) - longint'(qry_pts[k][c]);
      acc += 64'(d * d);
    end
    return COST_W'(int_sqrt(acc));
  endfunction

  // Full windowed DTW search over the shadow stores
  function automatic search_res_t dtw_search();
    search_res_t r;
    logic [COST_W-1:0] row[QMAX];
    logic [COST_W-1:0] dmat[][];
    logic [COST_W-1:0] best, diag, up, mn;
    int unsigned w, stop_i;
    bit have;
    w = win_len_reg;
    if (w < 1) w = 1;
    if (w > WMAX) w = WMAX;
    dmat = new[trj_cnt];
    for (int t = 0; t < trj_cnt; t++) begin
      dmat[t] = new[qry_cnt];
      for (int k = 0; k < qry_cnt; k++) dmat[t][k] = point_dist(t, k);
    end
    have = 0;
    best = 0;
    r = '0;
    for (int i = 0; i < trj_cnt; i++) begin
      stop_i = (trj_cnt - i > w) ? i + w : trj_cnt;
      for (int j = i; j < stop_i; j++) begin
        if (j == i) begin
          row[0] = dmat[j][0];
          for (int k = 1; k < qry_cnt; k++) row[k] = add_sat(dmat[j][k], row[k-1]);
        end else begin
          diag = row[0];
          row[0] = add_sat(dmat[j][0], row[0]);
          for (int k = 1; k < qry_cnt; k++) begin
            up = row[k];
            mn = (up < row[k-1]) ? up : row[k-1];
            if (diag < mn) mn = diag;
            row[k] = add_sat(dmat[j][k], mn);
            diag = up;
          end
        end
        if (!have || row[qry_cnt-1] < best) begin
          have = 1;
          best = row[qry_cnt-1];
          r.start = IDX_W'(i + 1);
          r.stop = IDX_W'(j + 1);
        end
      end
    end
    r.cost = best;
    r.status = ST_OK;
    return r;
  endfunction

  // Advance the shadow state by one accepted item
  task automatic predict_item(logic [1:0] rt, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    search_res_t r;
    if (rt == REQ_QUERY) begin
      if (qry_cnt < QMAX) begin
        qry_pts[qry_cnt] = '{x, y, z};
        qry_cnt++;
      end else begin
        overflowed = 1;
      end
    end else if (rt == REQ_TRAJ) begin
      if (trj_cnt < TMAX) begin
        trj_pts[trj_cnt] = '{x, y, z};
        trj_cnt++;
      end else begin
        overflowed = 1;
      end
    end else if (rt == REQ_RUN) begin
      r = '0;
      if (overflowed) r.status = ST_OVF;
      else if (qry_cnt == 0 || trj_cnt == 0) r.status = ST_EMPTY;
      else r = dtw_search();
      expected_results.push_back(r);
      qry_cnt = 0;
      trj_cnt = 0;
      overflowed = 0;
    end
  endtask

  // Sender: bursts with random gaps; the payload holds while stalled
  int burst_left;

  task automatic send_item(logic [1:0] rt, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_px <= x;
    in_py <= y;
    in_pz <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(rt, x, y, z);
    // Drop valid at the end of a burst
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic end_burst();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(COORD_W-1){1'b0}}};
      1: return {1'b0, {(COORD_W-1){1'b1}}};
      2: return COORD_W'($urandom);
      default: return COORD_W'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // Wait for every result, let the block settle, then write the window length
  task automatic drain();
    end_burst();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_window(logic [7:0] w);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len_reg = w;
  endtask

  task automatic load_set(int nq, int nt);
    for (int k = 0; k < nq; k++) send_item(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
    for (int k = 0; k < nt; k++) send_item(REQ_TRAJ, rand_coord(), rand_coord(), rand_coord());
  endtask

  // Result checker
  always @(posedge clk) begin
    search_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result cost=%0h start=%0d end=%0d status=%0d", $time,
                 out_best_cost, out_best_start, out_best_end, out_status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_best_cost !== want.cost) begin
          $display("%0t: best_cost expected %0h actual %0h", $time, want.cost, out_best_cost);
          errors++;
        end
        if (out_best_start !== want.start) begin
          $display("%0t: best_start expected %0d actual %0d", $time, want.start,
                   out_best_start);
          errors++;
        end
        if (out_best_end !== want.stop) begin
          $display("%0t: best_end expected %0d actual %0d", $time, want.stop, out_best_end);
          errors++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Directed: empty runs, extreme coordinates, window length extremes
  task automatic test_directed();
    logic signed [COORD_W-1:0] lo, hi;
    lo = {1'b1, {(COORD_W-1){1'b0}}};
    hi = {1'b0, {(COORD_W-1){1'b1}}};
    send_item(REQ_RUN, '0, '0, '0);
    send_item(REQ_QUERY, hi, lo, '0);
    send_item(REQ_RUN, '0, '0, '0);
    send_item(REQ_TRAJ, COORD_W'(1), COORD_W'(2), COORD_W'(3));
    send_item(REQ_RUN, '0, '0, '0);
    send_item(2'd3, hi, hi, hi);
    send_item(REQ_QUERY, lo, lo, lo);
    send_item(REQ_QUERY, hi, hi, hi);
    send_item(REQ_TRAJ, hi, hi, hi);
    send_item(REQ_TRAJ, lo, lo, lo);
    send_item(REQ_TRAJ, hi, lo, hi);
    send_item(REQ_RUN, '0, '0, '0);
    set_window(8'd0);
    load_set(2, 4);
    send_item(REQ_RUN, '1, '1, '1);
    set_window(8'd255);
    load_set(3, 5);
    send_item(REQ_RUN, '0, '0, '0);
    set_window(8'd1);
    load_set(1, 3);
    send_item(REQ_RUN, '0, '0, '0);
  endtask

  // Query store overflow: the run reports overflow and clears
  task automatic test_overflow();
    set_window(8'd4);
    load_set(QMAX + 1, 2);
    send_item(REQ_RUN, '0, '0, '0);
    load_set(2, 3);
    send_item(REQ_RUN, '0, '0, '0);
  endtask

  // Random sets of small sizes under changing window lengths
  task automatic test_random();
    int sent;
    logic [7:0] wl[] = '{8'd1, 8'd2, 8'd3, 8'd5, 8'd128, 8'd100, 8'd0};
    sent = 0;
    while (sent < 350) begin
      if ($urandom_range(0, 7) == 0) set_window(wl[$urandom_range(0, wl.size() - 1)]);
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 60);
      repeat ($urandom_range(1, 4)) begin
        int nq, nt;
        nq = $urandom_range(1, 6);
        nt = $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) nq = 0;
        if ($urandom_range(0, 9) == 0) nt = 0;
        load_set(nq, nt);
        if ($urandom_range(0, 15) == 0) send_item(2'd3, rand_coord(), rand_coord(), rand_coord());
        send_item(REQ_RUN, rand_coord(), rand_coord(), rand_coord());
        sent += nq + nt + 1;
      end
    end
  endtask

  // Long receiver hold-off while runs keep arriving
  task automatic test_backpressure();
    set_window(8'd2);
    hold_cycles = 400;
    for (int r = 0; r < 6; r++) begin
      load_set(1, 2);
      send_item(REQ_RUN, '0, '0, '0);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    qry_cnt = 0;
    trj_cnt = 0;
    overflowed = 0;
    win_len_reg = 8'd100;
    hold_cycles = 0;
    stall_pct = 20;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/wsds_pkg.sv
hw/rtl/wsds_isqrt.sv
hw/rtl/wsds_datapath.sv
hw/rtl/wsds_ctrl.sv
hw/rtl/windowed_subsequence_dtw_search.sv
tb/windowed_subsequence_dtw_search_tb.sv
